@@ rtl/xrr_pkg.sv @@
// Shared constants, opcodes and controller/datapath command and status types
// for the xorshift random generator with range reduction. No dependencies.
package xrr_pkg;

  localparam logic [31:0] DEFAULT_WORD = 32'hB3C3F00D;
  localparam logic [31:0] SEED_RESET   = 32'd3016224781;
  localparam logic [31:0] LCG_MUL      = 32'd1664525;
  localparam logic [31:0] LCG_ADD      = 32'd1013904223;

  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_BOUNDED = 2'd0,
    OP_RANGE   = 2'd1,
    OP_ENTROPY = 2'd2,
    OP_RESEED  = 2'd3
  } op_t;

  typedef struct packed {
    logic capture;
    logic advance;
    logic mix;
    logic reseed;
    logic div_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic range_empty;
  } sts_t;

  function automatic logic [31:0] xorshift(input logic [31:0] w);
    logic [31:0] a;
    logic [31:0] b;
    a = w ^ (w << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

@@ rtl/xrr_datapath.sv @@
// Datapath: generator word, seed register, entropy mixing, restoring
// remainder unit and the result register. Depends on xrr_pkg.
module xrr_datapath
  import xrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  opcode,
  input  logic [15:0] upper,
  input  logic [7:0]  lower,
  input  logic [15:0] entropy,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  output logic [15:0] value
);

  logic [31:0] seed;
  logic [31:0] gen;
  logic [31:0] dvd;
  logic [15:0] rem;
  logic [15:0] bound;
  logic [15:0] ent;
  logic [7:0]  low;
  op_t         op;
  logic        range_empty;

  logic [31:0] adv_word;
  logic [31:0] mix_in;
  logic [31:0] mix_word;
  logic [16:0] trial;
  logic [16:0] trial_sub;
  logic [7:0]  span;
  logic [7:0]  range_sum;
  logic [15:0] value_next;

  assign adv_word  = xorshift(gen);
  assign mix_in    = gen ^ {ent, ent};
  assign mix_word  = mix_in * LCG_MUL + LCG_ADD;
  assign trial     = {rem, dvd[31]};
  assign trial_sub = trial - {1'b0, bound};
  assign span      = upper[7:0] - lower;
  assign range_sum = low + rem[7:0];

  always_comb begin
    case (op)
      OP_BOUNDED: value_next = (bound == 16'd0) ? 16'd0 : rem;
      OP_RANGE:   value_next = range_empty ? {8'd0, low} : {8'd0, range_sum};
      default:    value_next = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
      gen  <= DEFAULT_WORD;
    end else begin
      if (seed_wr_en) begin
        seed <= seed_wr_data;
      end
      if (cmd.advance) begin
        gen <= adv_word;
      end else if (cmd.mix) begin
        gen <= mix_word;
      end else if (cmd.reseed) begin
        gen <= (seed == 32'd0) ? DEFAULT_WORD : seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op          <= op_t'(opcode);
      low         <= lower;
      ent         <= entropy;
      range_empty <= (upper[7:0] <= lower);
      bound       <= (op_t'(opcode) == OP_RANGE) ? {8'd0, span} : upper;
    end
    if (cmd.advance) begin
      dvd <= adv_word;
      rem <= 16'd0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[30:0], 1'b0};
      // The trial remainder never exceeds twice the bound, so one subtract suffices.
      rem <= (trial >= {1'b0, bound}) ? trial_sub[15:0] : trial[15:0];
    end
    if (cmd.publish) begin
      value <= value_next;
    end
  end

  assign sts.op          = op;
  assign sts.range_empty = range_empty;

endmodule

@@ rtl/xrr_ctrl.sv @@
// Controller: sequences capture, generator update, the remainder steps and
// the result beat, and owns both handshakes. Depends on xrr_pkg.
module xrr_ctrl
  import xrr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             slot_free;
  logic             draw;

  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign draw      = (sts.op == OP_BOUNDED) || (sts.op == OP_RANGE && !sts.range_empty);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && req_valid;
    cmd.advance  = (state == S_DECODE) && draw;
    cmd.mix      = (state == S_DECODE) && (sts.op == OP_ENTROPY);
    cmd.reseed   = (state == S_DECODE) && (sts.op == OP_RESEED);
    cmd.div_step = (state == S_DIVIDE);
    cmd.publish  = (state == S_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          cnt   <= '0;
          state <= draw ? S_DIVIDE : S_FINISH;
        end
        S_DIVIDE: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/xorshift_random_with_range.sv @@
// Top level of the xorshift random generator with range reduction.
// Depends on xrr_pkg, xrr_ctrl and xrr_datapath.
//
// A request beat carries an opcode: bounded draw, range draw, entropy mix or
// reseed. Draws advance a 32-bit xorshift word (13, 17, 5) and reduce it with
// a restoring remainder unit that retires one dividend bit per cycle. A draw
// runs from acceptance to result through capture, the generator advance, 32
// remainder steps and the load of the result register. Entropy mixing,
// reseeding and an empty range skip the remainder steps. One
// item is in flight at a time; the result register lets the next request be
// accepted while an earlier result beat is still stalled. Writing the seed
// takes effect at the next reseed and should be done while the block is idle.
module xorshift_random_with_range
  import xrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] upper,
  input  logic [7:0]  lower,
  input  logic [15:0] entropy,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] value,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data
);

  cmd_t cmd;
  sts_t sts;

  xrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  xrr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .upper        (upper),
    .lower        (lower),
    .entropy      (entropy),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .value        (value)
  );

endmodule

@@ bench/xorshift_random_with_range_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for xorshift_random_with_range: directed and random request beats
// are checked against a local predictor of the generator. Depends on xrr_pkg and the RTL.
module xorshift_random_with_range_tb
  import xrr_pkg::*;
;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    op_t         op;
    logic [15:0] upper;
    logic [7:0]  lower;
    logic [15:0] entropy;
  } req_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  opcode = '0;
  logic [15:0] upper = '0;
  logic [7:0]  lower = '0;
  logic [15:0] entropy = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [15:0] value;
  logic        seed_wr_en = 1'b0;
  logic [31:0] seed_wr_data = '0;

  req_item_t   op_backlog[$];
  logic [15:0] value_due[$];
  logic [31:0] gen_word;
  logic [31:0] seed_copy;
  int          beats_sent = 0;
  int          beats_taken = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          req_idle_pct = 0;
  int          rsp_idle_pct = 0;

  xorshift_random_with_range u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .opcode       (opcode),
    .upper        (upper),
    .lower        (lower),
    .entropy      (entropy),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .value        (value),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] xorshift_next(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w << 13);
    t = t ^ (t >> 17);
    return t ^ (t << 5);
  endfunction

  // Works out the value of one request and moves the generator word on accordingly.
  function automatic logic [15:0] predict_value(input req_item_t it);
    logic [7:0]  span;
    logic [31:0] mixed;
    logic [31:0] rem;
    logic [15:0] result;
    result = '0;
    case (it.op)
      OP_BOUNDED: begin
        gen_word = xorshift_next(gen_word);
        if (it.upper != 16'd0) begin
          rem = gen_word % {16'd0, it.upper};
          result = rem[15:0];
        end
      end
      OP_RANGE: begin
        if (it.upper[7:0] <= it.lower) begin
          result = {8'd0, it.lower};
        end else begin
          span = it.upper[7:0] - it.lower;
          gen_word = xorshift_next(gen_word);
          rem = gen_word % {24'd0, span};
          result = {8'd0, it.lower + rem[7:0]};
        end
      end
      OP_ENTROPY: begin
        mixed = gen_word ^ {it.entropy, it.entropy};
        gen_word = mixed * LCG_MUL + LCG_ADD;
      end
      default: begin
        gen_word = (seed_copy == 32'd0) ? DEFAULT_WORD : seed_copy;
      end
    endcase
    return result;
  endfunction

  function automatic req_item_t make_req(input op_t op, input logic [15:0] u,
                                         input logic [7:0] l, input logic [15:0] e);
    req_item_t it;
    it.op = op;
    it.upper = u;
    it.lower = l;
    it.entropy = e;
    return it;
  endfunction

  // Mostly draws; most range draws are well formed so that the generator really advances.
  function automatic req_item_t random_item();
    req_item_t it;
    int        pick;
    pick = $urandom_range(99);
    it.upper = 16'($urandom);
    it.lower = 8'($urandom);
    it.entropy = 16'($urandom);
    if (pick < 40) begin
      it.op = OP_BOUNDED;
      if ($urandom_range(3) == 0) begin
        it.upper = 16'($urandom_range(16));
      end
    end else if (pick < 78) begin
      it.op = OP_RANGE;
      if ($urandom_range(3) != 0 && it.lower != 8'hFF) begin
        it.upper[7:0] = 8'($urandom_range(255, it.lower + 1));
      end
    end else if (pick < 92) begin
      it.op = OP_ENTROPY;
    end else begin
      it.op = OP_RESEED;
    end
    return it;
  endfunction

  task automatic add_req(input req_item_t it);
    op_backlog.insert(op_backlog.size(), it);
  endtask

  task automatic queue_random(input int count);
    repeat (count) add_req(random_item());
  endtask

  task automatic drain_all();
    while (op_backlog.size() != 0 || req_valid || value_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] data);
    @(negedge clk);
    seed_wr_en <= 1'b1;
    seed_wr_data <= data;
    @(negedge clk);
    seed_wr_en <= 1'b0;
  endtask

  // Request driver and response stall generator.
  always @(negedge clk) begin : drive_req
    req_item_t item;
    logic      taken;
    taken = req_valid && (beats_taken == beats_sent);
    if (!rst && (!req_valid || taken)) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
        item = op_backlog.pop_front();
        opcode <= item.op;
        upper <= item.upper;
        lower <= item.lower;
        entropy <= item.entropy;
        req_valid <= 1'b1;
        beats_sent++;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
  end

  // Predicts on each accepted request beat and checks each accepted result beat.
  always @(posedge clk) begin : watch
    logic [15:0] want;
    logic        moved;
    moved = 1'b0;
    if (rst) begin
      gen_word = DEFAULT_WORD;
      seed_copy = SEED_RESET;
    end else begin
      if (seed_wr_en) begin
        seed_copy = seed_wr_data;
      end
      if (req_valid && !req_stall) begin
        value_due.insert(value_due.size(),
                         predict_value({op_t'(opcode), upper, lower, entropy}));
        beats_taken++;
        moved = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        if (value_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with nothing outstanding, value %h", $realtime, value);
          end
        end else begin
          want = value_due.pop_front();
          if (value !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: value mismatch, expected %h, got %h", $realtime, want, value);
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats with the seed left at its reset value.
    req_idle_pct = 13;
    rsp_idle_pct = 61;
    add_req(make_req(OP_BOUNDED, 16'h0000, 8'h00, 16'h0000));
    add_req(make_req(OP_BOUNDED, 16'h0001, 8'hFF, 16'hFFFF));
    add_req(make_req(OP_BOUNDED, 16'hFFFF, 8'h00, 16'h0000));
    add_req(make_req(OP_BOUNDED, 16'h8000, 8'h55, 16'h1234));
    add_req(make_req(OP_BOUNDED, 16'h0007, 8'h00, 16'h0000));
    add_req(make_req(OP_RANGE, 16'h0010, 8'h10, 16'h0000));
    add_req(make_req(OP_RANGE, 16'h0005, 8'h80, 16'h0000));
    add_req(make_req(OP_RANGE, 16'hFF00, 8'h00, 16'hFFFF));
    add_req(make_req(OP_RANGE, 16'h00FF, 8'h00, 16'h0000));
    add_req(make_req(OP_RANGE, 16'hAAFF, 8'hFE, 16'h0000));
    add_req(make_req(OP_RANGE, 16'h00FF, 8'hFF, 16'h0000));
    add_req(make_req(OP_RANGE, 16'h1234, 8'h30, 16'h0000));
    add_req(make_req(OP_ENTROPY, 16'h0000, 8'h00, 16'h0000));
    add_req(make_req(OP_ENTROPY, 16'hFFFF, 8'hFF, 16'hFFFF));
    add_req(make_req(OP_ENTROPY, 16'h0000, 8'h00, 16'hA5A5));
    add_req(make_req(OP_BOUNDED, 16'h0003, 8'h00, 16'h0000));
    add_req(make_req(OP_RESEED, 16'h0000, 8'h00, 16'h0000));
    add_req(make_req(OP_BOUNDED, 16'd100, 8'h00, 16'h0000));
    add_req(make_req(OP_ENTROPY, 16'hFFFF, 8'hFF, 16'h5A5A));
    add_req(make_req(OP_RESEED, 16'hFFFF, 8'hFF, 16'hFFFF));
    add_req(make_req(OP_RANGE, 16'h00C8, 8'h64, 16'h0000));
    drain_all();

    // A zero seed must bring back the default word.
    write_seed(32'h0000_0000);
    add_req(make_req(OP_RESEED, 16'h0000, 8'h00, 16'h0000));
    add_req(make_req(OP_BOUNDED, 16'hFFFF, 8'h00, 16'h0000));
    queue_random(480);
    drain_all();

    req_idle_pct = 61;
    rsp_idle_pct = 13;
    write_seed(32'hFFFF_FFFF);
    add_req(make_req(OP_RESEED, 16'h0000, 8'h00, 16'h0000));
    queue_random(480);
    drain_all();

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    write_seed($urandom);
    add_req(make_req(OP_RESEED, 16'h0000, 8'h00, 16'h0000));
    queue_random(490);
    drain_all();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && value_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
